FILE: rtl/arpm_pkg.sv
// ----------------------------------------------------------------------------
// arpm_pkg: shared types and constants of the AT response pattern monitor
// Command and status codes, register indexes, payload structs and the
// control struct that drives the row of window cells.
// ----------------------------------------------------------------------------
`default_nettype none

package arpm_pkg;

    // default sizes
    localparam int DEF_BUFFER_BYTES  = 256;
    localparam int DEF_PATTERN_BYTES = 8;
    localparam int DEF_SUCCESS_COUNT = 2;
    localparam int DEF_ERROR_COUNT   = 2;

    // fixed geometry of the pattern registers
    localparam int PAT_MAX_BYTES = 8;
    localparam int SLOT_COUNT    = 4;
    localparam int CFG_DATA_W    = 64;

    // pattern slots
    localparam int SLOT_SUCCESS_A = 0;
    localparam int SLOT_SUCCESS_B = 1;
    localparam int SLOT_ERROR_A   = 2;
    localparam int SLOT_ERROR_B   = 3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // command codes
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_code_t;

    // status codes
    typedef enum logic [2:0] {
        ST_WAITING  = 3'd0,
        ST_SUCCESS  = 3'd1,
        ST_FAILED   = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_code_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SUCCESS_A = 3'd0,
        REG_SUCCESS_B = 3'd1,
        REG_ERROR_A   = 3'd2,
        REG_ERROR_B   = 3'd3,
        REG_LENGTHS   = 3'd4,
        REG_TIMEOUT   = 3'd5
    } reg_index_t;

    // input transaction
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [2:0] status;
        logic [1:0] success_seen;
        logic [8:0] bytes_taken;
    } out_item_t;

    // pattern byte per slot, as seen by one cell
    typedef logic [SLOT_COUNT-1:0][7:0] slot_bytes_t;

    // window cell control
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/arpm_cell.sv
// ----------------------------------------------------------------------------
// arpm_cell: one position of the receive window
// Holds one byte, hands it to the next cell on a shift and compares the
// byte it will hold against the wanted byte of every pattern slot.
// ----------------------------------------------------------------------------
`default_nettype none

module arpm_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire arpm_pkg::cell_ctrl_t      ctrl,
    input  wire logic [7:0]                byte_in,
    input  wire arpm_pkg::slot_bytes_t     want,
    input  wire logic [arpm_pkg::SLOT_COUNT-1:0] care,
    output logic [7:0]                     byte_out,
    output logic [arpm_pkg::SLOT_COUNT-1:0] hit
);
    import arpm_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // next window byte
    always_comb begin
        if (ctrl.clear) begin
            byte_next = 8'd0;
        end else if (ctrl.shift) begin
            byte_next = byte_in;
        end else begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    // compare per slot, positions outside a pattern always agree
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            hit[s] = !care[s] || (byte_next == want[s]);
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

FILE: rtl/at_response_pattern_monitor.sv
// ----------------------------------------------------------------------------
// at_response_pattern_monitor: watches modem responses for end patterns
// Window of recent bytes in a row of cells, sticky success flags, error,
// overflow and receive timeout detection, one result per transaction.
// ----------------------------------------------------------------------------
// Every input transaction (start, received byte or time tick) yields exactly
// one result transaction carrying the status, the success flags and the byte
// count after that transaction. The block takes one transaction per clock
// cycle unless stalled, and the result appears in the cycle after acceptance:
// the window shift in the cell row, the parallel per-cell compares and the
// status update all complete in the accepting cycle, and a single output
// register holds the result. A new transaction is taken in the same cycle as
// a waiting result is taken downstream, so throughput stays at one per cycle
// whenever m_ready is high. Configuration writes are taken at any cycle with
// cfg_we high and must only be issued while no transaction is in flight.
`default_nettype none

module at_response_pattern_monitor #(
    parameter int BUFFER_BYTES  = arpm_pkg::DEF_BUFFER_BYTES,
    parameter int PATTERN_BYTES = arpm_pkg::DEF_PATTERN_BYTES,
    parameter int SUCCESS_COUNT = arpm_pkg::DEF_SUCCESS_COUNT,
    parameter int ERROR_COUNT   = arpm_pkg::DEF_ERROR_COUNT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [arpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire arpm_pkg::in_item_t            s_data,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output arpm_pkg::out_item_t                m_data
);
    import arpm_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    typedef logic [PAT_MAX_BYTES-1:0][7:0] pat_t;

    // configuration registers
    pat_t        pat_reg [SLOT_COUNT];
    logic [15:0] lengths_reg;
    logic [15:0] timeout_reg;

    // wait state
    logic [CNT_W-1:0] byte_counter_reg, byte_counter_next;
    logic [15:0]      idle_counter_reg, idle_counter_next;
    logic [1:0]       seen_reg, seen_next;
    logic             zero_seen_reg, zero_seen_next;
    logic [2:0]       status_reg, status_next;

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic                  accept;
    cell_ctrl_t            cell_ctrl;
    logic [3:0]            slot_len [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_match;
    logic [CNT_W-1:0]      count_inc;
    logic [15:0]           idle_limit;
    logic [15:0]           idle_inc;
    logic [1:0]            enabled;
    logic [CNT_W+8:0]      count_ext;

    logic [7:0]            cell_byte [PATTERN_BYTES];
    logic [SLOT_COUNT-1:0] cell_hit  [PATTERN_BYTES];

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                pat_reg[s] <= '0;
            end
            lengths_reg <= 16'd0;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SUCCESS_A: pat_reg[SLOT_SUCCESS_A] <= cfg_wdata;
                REG_SUCCESS_B: pat_reg[SLOT_SUCCESS_B] <= cfg_wdata;
                REG_ERROR_A:   pat_reg[SLOT_ERROR_A]   <= cfg_wdata;
                REG_ERROR_B:   pat_reg[SLOT_ERROR_B]   <= cfg_wdata;
                REG_LENGTHS:   lengths_reg <= cfg_wdata[15:0];
                REG_TIMEOUT:   timeout_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // slot lengths, clamped to the window, unused slots disabled
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_len[s] = lengths_reg[4*s +: 4];
            if (slot_len[s] > 4'(PATTERN_BYTES)) begin
                slot_len[s] = 4'(PATTERN_BYTES);
            end
        end
        if (SUCCESS_COUNT < 2) begin
            slot_len[SLOT_SUCCESS_B] = 4'd0;
        end
        if (ERROR_COUNT < 2) begin
            slot_len[SLOT_ERROR_B] = 4'd0;
        end
    end

    // window cell control
    always_comb begin
        cell_ctrl = '0;
        if (accept) begin
            if (s_data.cmd == CMD_START) begin
                cell_ctrl.clear = 1'b1;
            end else if (s_data.cmd == CMD_BYTE && status_reg == ST_WAITING) begin
                cell_ctrl.shift = 1'b1;
            end
        end
    end

    // row of window cells, newest byte in cell zero
    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
        localparam logic [3:0] POS = 4'(k);
        logic [7:0]            chain_in;
        slot_bytes_t           want;
        logic [SLOT_COUNT-1:0] care;

        if (k == 0) begin : g_head
            assign chain_in = s_data.rx_byte;
        end else begin : g_link
            assign chain_in = cell_byte[k-1];
        end

        // pattern byte that belongs at this position for each slot
        always_comb begin
            logic [3:0] idx;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                idx     = slot_len[s] - 4'd1 - POS;
                care[s] = slot_len[s] > POS;
                want[s] = pat_reg[s][idx[2:0]];
            end
        end

        arpm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .byte_in  (chain_in),
            .want     (want),
            .care     (care),
            .byte_out (cell_byte[k]),
            .hit      (cell_hit[k])
        );
    end

    assign count_inc = byte_counter_reg + CNT_W'(1);

    // combine the cell compares into one match per slot
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_match[s] = (slot_len[s] != 4'd0) && (count_inc >= CNT_W'(slot_len[s]));
            for (int k = 0; k < PATTERN_BYTES; k++) begin
                slot_match[s] = slot_match[s] && cell_hit[k][s];
            end
        end
    end

    assign enabled[0]  = slot_len[SLOT_SUCCESS_A] != 4'd0;
    assign enabled[1]  = slot_len[SLOT_SUCCESS_B] != 4'd0;
    assign idle_limit  = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign idle_inc    = (idle_counter_reg != 16'hFFFF) ? idle_counter_reg + 16'd1
                                                         : idle_counter_reg;

    // transaction step
    always_comb begin
        byte_counter_next = byte_counter_reg;
        idle_counter_next = idle_counter_reg;
        seen_next         = seen_reg;
        zero_seen_next    = zero_seen_reg;
        status_next       = status_reg;
        if (accept) begin
            case (s_data.cmd)
                CMD_START: begin
                    byte_counter_next = '0;
                    idle_counter_next = 16'd0;
                    seen_next         = 2'b00;
                    zero_seen_next    = 1'b0;
                    status_next       = ST_WAITING;
                end
                CMD_BYTE: begin
                    if (status_reg == ST_WAITING) begin
                        byte_counter_next = count_inc;
                        idle_counter_next = 16'd0;
                        zero_seen_next    = zero_seen_reg || (s_data.rx_byte == 8'd0);
                        if (!zero_seen_next) begin
                            seen_next = seen_reg | (slot_match[SLOT_SUCCESS_B:SLOT_SUCCESS_A]
                                                    & enabled);
                        end
                        if ((seen_next & enabled) == enabled) begin
                            status_next = ST_SUCCESS;
                        end else if (!zero_seen_next && (slot_match[SLOT_ERROR_A] ||
                                                         slot_match[SLOT_ERROR_B])) begin
                            status_next = ST_FAILED;
                        end else if (count_inc >= CNT_W'(BUFFER_BYTES)) begin
                            status_next = ST_OVERFLOW;
                        end
                    end
                end
                CMD_TICK: begin
                    if (status_reg == ST_WAITING) begin
                        idle_counter_next = idle_inc;
                        if (idle_inc >= idle_limit) begin
                            status_next = ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // wait state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_counter_reg <= '0;
            idle_counter_reg <= 16'd0;
            seen_reg         <= 2'b00;
            zero_seen_reg    <= 1'b0;
            status_reg       <= ST_WAITING;
        end else begin
            byte_counter_reg <= byte_counter_next;
            idle_counter_reg <= idle_counter_next;
            seen_reg         <= seen_next;
            zero_seen_reg    <= zero_seen_next;
            status_reg       <= status_next;
        end
    end

    // result register
    assign count_ext = (CNT_W+9)'(byte_counter_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.status       <= status_next;
            m_data_reg.success_seen <= seen_next;
            m_data_reg.bytes_taken  <= count_ext[8:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a start transaction gives an all-zero result
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.cmd == CMD_START) |=> (m_valid && m_data == '0))
        else $error("start did not clear the result");

    // byte count stays within the buffer
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_counter_reg <= CNT_W'(BUFFER_BYTES))
        else $error("byte count beyond buffer size");

    // a finished wait only ends with a start
    a_status_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg != ST_WAITING && !(accept && s_data.cmd == CMD_START))
        |=> (status_reg == $past(status_reg)))
        else $error("final status changed without start");

    // a byte taken while waiting is counted and restarts the idle time
    a_byte_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.cmd == CMD_BYTE && status_reg == ST_WAITING)
        |=> (byte_counter_reg == $past(count_inc) && idle_counter_reg == 16'd0))
        else $error("byte not counted");

    // result follows the state it reports
    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_data.status == status_reg && m_data.success_seen == seen_reg))
        else $error("result differs from state");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/arpm_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_tb_pkg: response predictor and scoreboard for the pattern monitor
// Keeps its own copy of the registers and of the wait state, works out the
// result of every accepted input transaction and checks the results of the
// block against them in order.
// ----------------------------------------------------------------------------
package arpm_tb_pkg;

    import arpm_pkg::*;

    class response_scoreboard;

        // register copy
        logic [63:0]  pattern [SLOT_COUNT];
        logic [15:0]  lengths;
        logic [15:0]  timeout;

        // wait state
        logic [7:0]   window [PAT_MAX_BYTES];
        logic [1:0]   seen;
        logic [8:0]   nbytes;
        logic [15:0]  idle_ticks;
        bit           nul_seen;
        status_code_t status;

        out_item_t    expected_q [$];
        int           errors;
        int           live_items;

        function new();
            foreach (pattern[i]) pattern[i] = '0;
            lengths    = '0;
            timeout    = TIMEOUT_RESET;
            errors     = 0;
            live_items = 0;
            clear_wait();
        endfunction

        function void clear_wait();
            foreach (window[i]) window[i] = '0;
            seen       = '0;
            nbytes     = '0;
            idle_ticks = '0;
            nul_seen   = 1'b0;
            status     = ST_WAITING;
        endfunction

        function void write_reg(reg_index_t r, logic [63:0] v);
            case (r)
                REG_SUCCESS_A: pattern[SLOT_SUCCESS_A] = v;
                REG_SUCCESS_B: pattern[SLOT_SUCCESS_B] = v;
                REG_ERROR_A:   pattern[SLOT_ERROR_A] = v;
                REG_ERROR_B:   pattern[SLOT_ERROR_B] = v;
                REG_LENGTHS:   lengths = v[15:0];
                REG_TIMEOUT:   timeout = v[15:0];
                default: ;
            endcase
        endfunction

        // length nibble of a slot, clamped to the window size
        function int unsigned slot_len(int slot);
            int unsigned n;
            n = lengths[4*slot +: 4];
            if (n > DEF_PATTERN_BYTES) n = DEF_PATTERN_BYTES;
            return n;
        endfunction

        // newest len bytes equal the pattern, first char oldest
        function bit ends_with(logic [63:0] pat, int unsigned len);
            if (len == 0 || nbytes < len) return 1'b0;
            for (int unsigned k = 0; k < len; k++)
                if (window[len-1-k] !== pat[8*k +: 8]) return 1'b0;
            return 1'b1;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [1:0] enabled;
            for (int k = PAT_MAX_BYTES - 1; k > 0; k--) window[k] = window[k-1];
            window[0]  = b;
            nbytes     = nbytes + 1'b1;
            idle_ticks = '0;
            if (b == 8'h00) nul_seen = 1'b1;

            enabled = '0;
            for (int s = 0; s < 2; s++)
                if (s < DEF_SUCCESS_COUNT && slot_len(SLOT_SUCCESS_A + s) != 0)
                    enabled[s] = 1'b1;

            // sticky success flags, no matching past a nul
            if (!nul_seen)
                for (int s = 0; s < 2; s++)
                    if (enabled[s] && ends_with(pattern[SLOT_SUCCESS_A + s],
                                                slot_len(SLOT_SUCCESS_A + s)))
                        seen[s] = 1'b1;

            if ((seen & enabled) == enabled) begin
                status = ST_SUCCESS;
                return;
            end
            if (!nul_seen)
                for (int e = 0; e < 2; e++)
                    if (e < DEF_ERROR_COUNT && ends_with(pattern[SLOT_ERROR_A + e],
                                                         slot_len(SLOT_ERROR_A + e))) begin
                        status = ST_FAILED;
                        return;
                    end
            if (nbytes >= DEF_BUFFER_BYTES) status = ST_OVERFLOW;
        endfunction

        function void take_tick();
            int unsigned limit;
            limit = (timeout == 0) ? 1 : timeout;
            if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 1'b1;
            if (idle_ticks >= limit) status = ST_TIMEOUT;
        endfunction

        // accepted input transaction: advance the state, queue the result
        function void note_input(in_item_t it);
            out_item_t want;
            if (it.cmd == CMD_START) begin
                clear_wait();
                live_items++;
            end else if (status == ST_WAITING) begin
                if (it.cmd == CMD_BYTE) begin
                    take_byte(it.rx_byte);
                    live_items++;
                end else if (it.cmd == CMD_TICK) begin
                    take_tick();
                    live_items++;
                end
            end
            want.status       = status;
            want.success_seen = seen;
            want.bytes_taken  = nbytes;
            expected_q.push_back(want);
        endfunction

        task report(string msg);
            if (errors < 40) $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // accepted result transaction against the oldest expectation
        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %h with no transaction pending", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.success_seen !== want.success_seen)
                report($sformatf("success_seen %b, expected %b",
                                 got.success_seen, want.success_seen));
            if (got.bytes_taken !== want.bytes_taken)
                report($sformatf("bytes_taken %0d, expected %0d",
                                 got.bytes_taken, want.bytes_taken));
        endtask

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

FILE: tb/sv/tb_at_response_pattern_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_at_response_pattern_monitor: self-checking bench for the pattern monitor
// Directed byte streams for success, failure, nul and timeout endings, then
// random start/byte/tick sequences under several register settings and
// handshake idling patterns, every result checked against a predictor.
// ----------------------------------------------------------------------------
module tb_at_response_pattern_monitor;

    import arpm_pkg::*;
    import arpm_tb_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASE_ITEMS    = 140;
    localparam int          PHASE_COUNT    = 8;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          HOLD_CYCLES    = 60;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;

    response_scoreboard sb;
    logic [63:0] reg_shadow [6];
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          hold_cycles     = 0;
    int          quiet_cycles    = 0;

    at_response_pattern_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // transaction monitor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // offer one transaction after random idle cycles, return on acceptance
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        in_item_t it;
        it.cmd     = cmd;
        it.rx_byte = b;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_item(CMD_BYTE, txt[i]);
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all registers from the shadow copy, block idle
    task automatic write_all_regs();
        reg_index_t r;
        r = REG_SUCCESS_A;
        do begin
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_wdata <= reg_shadow[r];
            sb.write_reg(r, reg_shadow[r]);
            @(posedge aclk);
            r = r.next();
        end while (r != REG_SUCCESS_A);
        cfg_we <= 1'b0;
    endtask

    // bytes biased towards a small alphabet so patterns turn up
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 31);
        if (r < 24) return 8'h41 + r % 4;
        if (r < 28) return (r % 2) ? 8'h0D : 8'h0A;
        if (r < 31) return $urandom_range(0, 255);
        return 8'h00;
    endfunction

    // start, then random bytes, pattern runs, ticks and noise
    task automatic run_sequence(input bit long_run);
        int steps;
        int r;
        int s;
        int n;
        steps = long_run ? DEF_BUFFER_BYTES + 6 : $urandom_range(1, 20);
        send_item(CMD_START, $urandom_range(0, 255));
        for (int i = 0; i < steps; i++) begin
            if (sb.status != ST_WAITING && $urandom_range(0, 3) != 0) break;
            r = $urandom_range(0, 99);
            if (long_run) begin
                send_item(CMD_BYTE, $urandom_range(0, 255));
            end else if (r < 20) begin
                s = $urandom_range(0, SLOT_COUNT - 1);
                n = sb.slot_len(s);
                if (n == 0) n = 3;
                for (int k = 0; k < n; k++) send_item(CMD_BYTE, sb.pattern[s][8*k +: 8]);
            end else if (r < 58) begin
                send_item(CMD_BYTE, pick_byte());
            end else if (r < 61) begin
                send_item(CMD_BYTE, 8'h00);
            end else if (r < 80) begin
                // tick run, sometimes long enough to time out
                n = ($urandom_range(0, 3) == 0) ? sb.timeout + 1 : $urandom_range(1, 3);
                if (n > 20) n = 20;
                repeat (n) send_item(CMD_TICK, $urandom_range(0, 255));
            end else if (r < 86) begin
                send_item(CMD_UNUSED, $urandom_range(0, 255));
            end else if (r < 89) begin
                send_item(CMD_START, $urandom_range(0, 255));
            end else begin
                send_item(CMD_BYTE, $urandom_range(0, 255));
            end
        end
    endtask

    // stimulus
    initial begin : main_flow
        int goal;
        bit held;
        bit paused;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: nothing enabled, first byte succeeds, rest ignored
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_UNUSED, 8'hFF);
        drain();

        // "OK" and CRLF to succeed, "NO" or a single 0xff to fail
        reg_shadow[REG_SUCCESS_A] = 64'h4B4F;
        reg_shadow[REG_SUCCESS_B] = 64'h0A0D;
        reg_shadow[REG_ERROR_A]   = 64'h4F4E;
        reg_shadow[REG_ERROR_B]   = 64'hFF;
        reg_shadow[REG_LENGTHS]   = 64'h1222;
        reg_shadow[REG_TIMEOUT]   = 64'd2;
        write_all_regs();
        send_item(CMD_START, 8'h00);
        send_text("OK\r\n");
        send_item(CMD_START, 8'h00);
        send_text("NO");
        // nul byte stops matching, ticks then time out
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'h00);
        send_text("OK");
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        drain();

        // random phases
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin sender_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            case (p)
                4: begin
                    for (int i = 0; i < SLOT_COUNT; i++) reg_shadow[i] = '1;
                    reg_shadow[REG_LENGTHS] = 64'hFFFF;
                    reg_shadow[REG_TIMEOUT] = 64'hFFFF;
                end
                5: begin
                    foreach (reg_shadow[i]) reg_shadow[i] = '0;
                end
                default: begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                        for (int k = 0; k < PAT_MAX_BYTES; k++)
                            reg_shadow[i][8*k +: 8] = pick_byte();
                    reg_shadow[REG_LENGTHS] = '0;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        case ($urandom_range(0, 9))
                            0, 1:       reg_shadow[REG_LENGTHS][4*i +: 4] = 4'd0;
                            2, 3, 4, 5,
                            6:          reg_shadow[REG_LENGTHS][4*i +: 4] = $urandom_range(1, 3);
                            7, 8:       reg_shadow[REG_LENGTHS][4*i +: 4] = $urandom_range(4, 8);
                            default:    reg_shadow[REG_LENGTHS][4*i +: 4] = $urandom_range(9, 15);
                        endcase
                    end
                    case ($urandom_range(0, 9))
                        0:       reg_shadow[REG_TIMEOUT] = 64'd0;
                        1:       reg_shadow[REG_TIMEOUT] = 64'd1;
                        default: reg_shadow[REG_TIMEOUT] = $urandom_range(2, 10);
                    endcase
                end
            endcase
            write_all_regs();

            goal   = sb.live_items + PHASE_ITEMS;
            held   = 1'b0;
            paused = 1'b0;
            // full buffer run ending in overflow
            if (p == 0 || p == 4) run_sequence(1'b1);
            while (sb.live_items < goal) begin
                // long result hold-off while the sender keeps offering
                if (p == 2 && !held && sb.live_items > goal - PHASE_ITEMS / 2) begin
                    hold_cycles = HOLD_CYCLES;
                    held        = 1'b1;
                end
                // sender pause until the block has emptied
                if (p == 1 && !paused && sb.live_items > goal - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                run_sequence(1'b0);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/arpm_pkg.sv
rtl/arpm_cell.sv
rtl/at_response_pattern_monitor.sv
tb/sv/arpm_tb_pkg.sv
tb/sv/tb_at_response_pattern_monitor.sv
